[rtl/sound_meter_poll_protocol_assert.svh]
// Assertion macros used by the checker file of the sound meter poll block.
`ifndef SOUND_METER_POLL_PROTOCOL_ASSERT_SVH
`define SOUND_METER_POLL_PROTOCOL_ASSERT_SVH

// Property that is checked only outside reset.
`define SMPP_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property that is checked at every edge, reset included.
`define SMPP_ASSERT_ALWAYS(label, clk, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/smpp_pkg.sv]
// ----------------------------------------------------------------------------
// smpp_pkg
// Types and constants of the sound meter poll protocol engine.
// ----------------------------------------------------------------------------
`default_nettype none

package smpp_pkg;

	typedef enum logic [1:0] {
		PH_SEND_INIT = 2'd0,
		PH_GET_INIT  = 2'd1,
		PH_SEND_REQ  = 2'd2,
		PH_GET_PKT   = 2'd3
	} phase_t;

	localparam logic [1:0] KIND_POLL    = 2'd0;
	localparam logic [1:0] KIND_BYTE    = 2'd1;
	localparam logic [1:0] KIND_TIMEOUT = 2'd2;

	localparam logic [2:0] EV_NONE         = 3'd0;
	localparam logic [2:0] EV_INIT_OK      = 3'd1;
	localparam logic [2:0] EV_INIT_BAD     = 3'd2;
	localparam logic [2:0] EV_INIT_TIMEOUT = 3'd3;
	localparam logic [2:0] EV_READING      = 3'd4;
	localparam logic [2:0] EV_ZERO_READING = 3'd5;
	localparam logic [2:0] EV_BAD_REPLY    = 3'd6;
	localparam logic [2:0] EV_PKT_TIMEOUT  = 3'd7;

	localparam logic [7:0] CMD_INIT_0  = 8'h10;
	localparam logic [7:0] CMD_INIT_1  = 8'h04;
	localparam logic [7:0] CMD_REQ_0   = 8'h30;
	localparam logic [7:0] BYTE_CR     = 8'h0d;
	localparam logic [7:0] INIT_ACK    = 8'h05;
	localparam logic [6:0] BASE_MIN_DB = 7'd40;

	typedef struct packed {
		logic        tx_valid;
		logic [7:0]  tx_byte;
		logic [2:0]  event_res;
		logic [10:0] level_tenths;
		logic        weighting_c;
		logic        slow_mode;
		logic [6:0]  base_level;
		logic        last;
	} result_t;

	typedef struct packed {
		phase_t     phase;
		logic [1:0] cnt;
	} state_t;

	typedef struct packed {
		logic [1:0] num_res;
		result_t    res;
		state_t     nxt;
		logic       wr_en;
	} step_t;

endpackage

`default_nettype wire

[rtl/smpp_if.sv]
// ----------------------------------------------------------------------------
// smpp_if
// Channel interfaces: input items, configuration writes and result items.
// ----------------------------------------------------------------------------
`default_nettype none

interface smpp_cmd_if;
	logic       valid;
	logic       ready;
	logic [1:0] kind;
	logic [7:0] rx_byte;
	modport source (output valid, kind, rx_byte, input ready);
	modport sink (input valid, kind, rx_byte, output ready);
endinterface

interface smpp_cfg_if;
	logic       valid;
	logic       ready;
	logic [7:0] data;
	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

interface smpp_res_if;
	logic        valid;
	logic        ready;
	logic        tx_valid;
	logic [7:0]  tx_byte;
	logic [2:0]  event_res;
	logic [10:0] level_tenths;
	logic        weighting_c;
	logic        slow_mode;
	logic [6:0]  base_level;
	logic        last;
	modport source (output valid, tx_valid, tx_byte, event_res, level_tenths, weighting_c,
		slow_mode, base_level, last, input ready);
	modport sink (input valid, tx_valid, tx_byte, event_res, level_tenths, weighting_c,
		slow_mode, base_level, last, output ready);
endinterface

`default_nettype wire

[rtl/smpp_step.sv]
// ----------------------------------------------------------------------------
// smpp_step
// Protocol decision for one item: result count, one result beat, next state.
// ----------------------------------------------------------------------------
`default_nettype none

module smpp_step import smpp_pkg::*; (
	input  state_t     cur,
	input  logic [7:0] reply0,
	input  logic [7:0] reply1,
	input  logic [7:0] reply2,
	input  logic [7:0] tag,
	input  logic [1:0] kind,
	input  logic [7:0] rx_byte,
	input  logic [1:0] beat,
	output step_t      step
);

	logic [10:0] level;
	logic        pkt_ok;
	logic [7:0]  tag_next;
	result_t     ev_res;
	result_t     cmd_res;
	logic [7:0]  cmd_b0;
	logic [7:0]  cmd_b1;

	always_comb begin
		tag_next = tag + 8'd1;
		level    = {reply0[2:0], reply1};
		pkt_ok   = (reply2 == tag_next) && (rx_byte == BYTE_CR);

		cmd_b0 = (cur.phase == PH_SEND_INIT) ? CMD_INIT_0 : CMD_REQ_0;
		cmd_b1 = (cur.phase == PH_SEND_INIT) ? CMD_INIT_1 : tag;

		cmd_res          = '0;
		cmd_res.tx_valid = 1'b1;
		case (beat)
			2'd0:    cmd_res.tx_byte = cmd_b0;
			2'd1:    cmd_res.tx_byte = cmd_b1;
			default: cmd_res.tx_byte = BYTE_CR;
		endcase
		cmd_res.last = (beat == 2'd2);

		ev_res      = '0;
		ev_res.last = 1'b1;

		step         = '0;
		step.nxt     = cur;
		step.res     = ev_res;

		case (kind)
			KIND_POLL: begin
				if (cur.phase == PH_SEND_INIT || cur.phase == PH_SEND_REQ) begin
					step.num_res   = 2'd3;
					step.res       = cmd_res;
					step.nxt.phase = (cur.phase == PH_SEND_INIT) ? PH_GET_INIT : PH_GET_PKT;
					step.nxt.cnt   = 2'd0;
				end
			end
			KIND_BYTE: begin
				if (cur.phase == PH_GET_INIT) begin
					step.wr_en = 1'b1;
					if (cur.cnt == 2'd0) begin
						step.nxt.cnt = 2'd1;
					end else begin
						step.num_res = 2'd1;
						step.nxt.cnt = 2'd0;
						if (reply0 == INIT_ACK && rx_byte == BYTE_CR) begin
							step.nxt.phase       = PH_SEND_REQ;
							step.res.event_res = EV_INIT_OK;
						end else begin
							step.nxt.phase       = PH_SEND_INIT;
							step.res.event_res = EV_INIT_BAD;
						end
					end
				end else if (cur.phase == PH_GET_PKT) begin
					step.wr_en = 1'b1;
					if (cur.cnt != 2'd3) begin
						step.nxt.cnt = cur.cnt + 2'd1;
					end else begin
						step.num_res   = 2'd1;
						step.nxt.cnt   = 2'd0;
						step.nxt.phase = PH_SEND_REQ;
						if (pkt_ok) begin
							step.res.event_res    = (level == 11'd0) ? EV_ZERO_READING : EV_READING;
							step.res.level_tenths = level;
							step.res.weighting_c  = reply0[7];
							step.res.slow_mode    = reply0[3];
							step.res.base_level   = BASE_MIN_DB + {1'b0, reply0[5:4], 4'b0000}
								+ {3'b000, reply0[5:4], 2'b00};
						end else begin
							step.res.event_res = EV_BAD_REPLY;
						end
					end
				end
			end
			KIND_TIMEOUT: begin
				if (cur.phase == PH_GET_INIT || cur.phase == PH_GET_PKT) begin
					step.num_res       = 2'd1;
					step.nxt.phase     = PH_SEND_REQ;
					step.nxt.cnt       = 2'd0;
					step.res.event_res = (cur.phase == PH_GET_INIT) ? EV_INIT_TIMEOUT
						: EV_PKT_TIMEOUT;
				end
			end
			default: begin
				step.num_res = 2'd0;
			end
		endcase
	end

endmodule

`default_nettype wire

[rtl/sound_meter_poll_protocol.sv]
// ----------------------------------------------------------------------------
// sound_meter_poll_protocol
// Host-side poll engine for a serial sound meter.
// ----------------------------------------------------------------------------
// Input items arrive on cmd (kind, rx_byte); each is taken when valid and
// ready are both high. A poll in a sending phase produces three command-byte
// results, a completed reply or a timeout in a waiting phase produces one
// event result, and every other item produces none. Results leave on res,
// the final one of an item marked by last. The request tag is written on cfg,
// which is always ready, and should only be changed while the block is idle.
// An accepted item is held in an input register, and its first result is
// loaded into the output register once that register is free, from where
// it is offered on res. The output register hands out one result per cycle
// while the receiver keeps res.ready high, so a poll holds the input
// register until its third result is loaded, and the next item is taken in
// the cycle that the current one finishes.
// When the receiver holds res.ready low the result register keeps its value
// and cmd.ready drops once the input register holds an unfinished item.
// Reset puts the engine in the init phase with tag 0 and no results pending.
// ----------------------------------------------------------------------------
`default_nettype none

module sound_meter_poll_protocol import smpp_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	smpp_cmd_if.sink  cmd,
	smpp_cfg_if.sink  cfg,
	smpp_res_if.source res
);

	logic       valid_s1;
	logic [1:0] kind_s1;
	logic [7:0] rx_byte_s1;
	logic [1:0] beat_q;
	state_t     state_q;
	logic [7:0] tag_q;
	logic [7:0] reply_q [4];
	logic       out_valid_q;
	result_t    out_q;

	step_t step;
	logic  out_free;
	logic  load_out;
	logic  done;
	logic  in_ready;

	smpp_step u_step (
		.cur     (state_q),
		.reply0  (reply_q[0]),
		.reply1  (reply_q[1]),
		.reply2  (reply_q[2]),
		.tag     (tag_q),
		.kind    (kind_s1),
		.rx_byte (rx_byte_s1),
		.beat    (beat_q),
		.step    (step)
	);

	always_comb begin
		out_free = !out_valid_q || res.ready;
		load_out = valid_s1 && (step.num_res != 2'd0) && out_free;
		done     = valid_s1 && ((step.num_res == 2'd0)
			|| (out_free && beat_q == step.num_res - 2'd1));
		in_ready = !valid_s1 || done;
	end

	assign cmd.ready = in_ready;
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			beat_q      <= 2'd0;
			state_q     <= '{phase: PH_SEND_INIT, cnt: 2'd0};
			tag_q       <= 8'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= cmd.valid;
			end
			if (done) begin
				beat_q  <= 2'd0;
				state_q <= step.nxt;
			end else if (load_out) begin
				beat_q <= beat_q + 2'd1;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg.valid) begin
				tag_q <= cfg.data;
			end
		end
	end

	// Payload registers carry no reset.
	always_ff @(posedge clk) begin
		if (in_ready && cmd.valid) begin
			kind_s1    <= cmd.kind;
			rx_byte_s1 <= cmd.rx_byte;
		end
		if (done && step.wr_en) begin
			reply_q[state_q.cnt] <= rx_byte_s1;
		end
		if (load_out) begin
			out_q <= step.res;
		end
	end

	assign res.valid        = out_valid_q;
	assign res.tx_valid     = out_q.tx_valid;
	assign res.tx_byte      = out_q.tx_byte;
	assign res.event_res    = out_q.event_res;
	assign res.level_tenths = out_q.level_tenths;
	assign res.weighting_c  = out_q.weighting_c;
	assign res.slow_mode    = out_q.slow_mode;
	assign res.base_level   = out_q.base_level;
	assign res.last         = out_q.last;

endmodule

`default_nettype wire

[rtl/smpp_checker.sv]
// ----------------------------------------------------------------------------
// smpp_checker
// Port-level checks of the sound meter poll engine, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sound_meter_poll_protocol_assert.svh"

module smpp_checker import smpp_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        res_valid,
	input logic        res_ready,
	input logic        res_tx_valid,
	input logic [2:0]  res_event_res,
	input logic [10:0] res_level_tenths,
	input logic [6:0]  res_base_level,
	input logic        res_last
);

	// A result waiting for the receiver must not disappear.
	`SMPP_ASSERT(a_res_hold, clk, arst_n, res_valid && !res_ready |=> res_valid, "result dropped while stalled")

	// Once a command byte other than the last of a poll is taken, the next one is offered without a gap.
	`SMPP_ASSERT(a_cmd_burst, clk, arst_n, res_valid && res_ready && res_tx_valid && !res_last |=> res_valid, "gap inside a command transaction burst")

	// Only readings carry level and range fields.
	`SMPP_ASSERT(a_no_level, clk, arst_n, res_valid && res_event_res != EV_READING && res_event_res != EV_ZERO_READING |-> res_level_tenths == 11'd0 && res_base_level == 7'd0, "level fields set outside a reading")

	// Once reset has been seen at an edge, no result is offered at the next one.
	`SMPP_ASSERT_ALWAYS(a_reset_idle, clk, !arst_n |=> !res_valid, "result offered after reset")

endmodule

bind sound_meter_poll_protocol smpp_checker u_smpp_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.res_valid        (res.valid),
	.res_ready        (res.ready),
	.res_tx_valid     (res.tx_valid),
	.res_event_res    (res.event_res),
	.res_level_tenths (res.level_tenths),
	.res_base_level   (res.base_level),
	.res_last         (res.last)
);

`default_nettype wire

[test/poll_protocol_checker.sv]
// ----------------------------------------------------------------------------
// poll_protocol_checker
// Watches the item, tag and result channels of the poll engine. It keeps its
// own copy of the protocol state, works out the results of every accepted
// item and compares each result transaction field by field with them.
// ----------------------------------------------------------------------------
module poll_protocol_checker import smpp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	smpp_cmd_if        cmd,
	smpp_cfg_if        cfg,
	smpp_res_if        res,
	output int         fail_count,
	output int         pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [6:0] RANGE_STEP_DB = 7'd20;

	logic [7:0] tag;
	phase_t     phase;
	logic [1:0] nbytes;
	logic [7:0] reply [0:3];
	result_t    awaited_results [$];

	initial fail_count = 0;

	task automatic report_error(input string msg);
		fail_count++;
		$display("MISMATCH at %0t ns: %s", $time, msg);
	endtask

	task automatic push_result(input logic txv, input logic [7:0] txb, input logic [2:0] ev,
		input logic [10:0] lvl, input logic wc, input logic sm, input logic [6:0] base,
		input logic lst);
		result_t r;
		r.tx_valid     = txv;
		r.tx_byte      = txb;
		r.event_res    = ev;
		r.level_tenths = lvl;
		r.weighting_c  = wc;
		r.slow_mode    = sm;
		r.base_level   = base;
		r.last         = lst;
		awaited_results.push_back(r);
	endtask

	task automatic push_command(input logic [7:0] b0, input logic [7:0] b1,
		input logic [7:0] b2);
		push_result(1'b1, b0, EV_NONE, '0, 1'b0, 1'b0, '0, 1'b0);
		push_result(1'b1, b1, EV_NONE, '0, 1'b0, 1'b0, '0, 1'b0);
		push_result(1'b1, b2, EV_NONE, '0, 1'b0, 1'b0, '0, 1'b1);
	endtask

	task automatic push_event(input logic [2:0] ev);
		push_result(1'b0, 8'h00, ev, '0, 1'b0, 1'b0, '0, 1'b1);
	endtask

	// A packet is good only when its third byte is the tag plus one, taken
	// modulo 256, and its fourth byte is a carriage return.
	task automatic finish_packet();
		logic [7:0]  tag_next;
		logic [7:0]  b0;
		logic [10:0] lvl;
		tag_next = tag + 8'd1;
		b0 = reply[0];
		lvl = {b0[2:0], reply[1]};
		phase = PH_SEND_REQ;
		if (reply[2] != tag_next || reply[3] != BYTE_CR) begin
			push_event(EV_BAD_REPLY);
		end else begin
			push_result(1'b0, 8'h00, (lvl == '0) ? EV_ZERO_READING : EV_READING, lvl, b0[7],
				b0[3], BASE_MIN_DB + RANGE_STEP_DB * 7'(b0[5:4]), 1'b1);
		end
	endtask

	task automatic step_poll_engine(input logic [1:0] kind, input logic [7:0] rx);
		case (kind)
			KIND_POLL: begin
				if (phase == PH_SEND_INIT) begin
					phase = PH_GET_INIT;
					nbytes = '0;
					push_command(CMD_INIT_0, CMD_INIT_1, BYTE_CR);
				end else if (phase == PH_SEND_REQ) begin
					phase = PH_GET_PKT;
					nbytes = '0;
					push_command(CMD_REQ_0, tag, BYTE_CR);
				end
			end
			KIND_BYTE: begin
				if (phase == PH_GET_INIT) begin
					reply[nbytes] = rx;
					if (nbytes == 2'd0) begin
						nbytes = 2'd1;
					end else begin
						nbytes = '0;
						if (reply[0] == INIT_ACK && reply[1] == BYTE_CR) begin
							phase = PH_SEND_REQ;
							push_event(EV_INIT_OK);
						end else begin
							phase = PH_SEND_INIT;
							push_event(EV_INIT_BAD);
						end
					end
				end else if (phase == PH_GET_PKT) begin
					reply[nbytes] = rx;
					if (nbytes != 2'd3) begin
						nbytes = nbytes + 2'd1;
					end else begin
						nbytes = '0;
						finish_packet();
					end
				end
			end
			KIND_TIMEOUT: begin
				if (phase == PH_GET_INIT) begin
					phase = PH_SEND_REQ;
					nbytes = '0;
					push_event(EV_INIT_TIMEOUT);
				end else if (phase == PH_GET_PKT) begin
					phase = PH_SEND_REQ;
					nbytes = '0;
					push_event(EV_PKT_TIMEOUT);
				end
			end
			default: ;
		endcase
	endtask

	task automatic check_field(input string name, input logic [10:0] got,
		input logic [10:0] want);
		if (got !== want)
			report_error($sformatf("%s is %0h, expected %0h", name, got, want));
	endtask

	task automatic check_result();
		result_t want;
		if (awaited_results.size() == 0) begin
			report_error($sformatf("result with none awaited: tx_valid %0b tx_byte %02h event %0d",
				res.tx_valid, res.tx_byte, res.event_res));
			return;
		end
		want = awaited_results.pop_front();
		check_field("tx_valid", 11'(res.tx_valid), 11'(want.tx_valid));
		check_field("tx_byte", 11'(res.tx_byte), 11'(want.tx_byte));
		check_field("event_res", 11'(res.event_res), 11'(want.event_res));
		check_field("level_tenths", res.level_tenths, want.level_tenths);
		check_field("weighting_c", 11'(res.weighting_c), 11'(want.weighting_c));
		check_field("slow_mode", 11'(res.slow_mode), 11'(want.slow_mode));
		check_field("base_level", 11'(res.base_level), 11'(want.base_level));
		check_field("last", 11'(res.last), 11'(want.last));
	endtask

	// A result is taken only after its item has passed the input register, so a
	// result is always compared before the same edge's item is modelled.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag = '0;
			phase = PH_SEND_INIT;
			nbytes = '0;
			awaited_results.delete();
			pending = 0;
		end else begin
			if (res.valid && res.ready)
				check_result();
			if (cfg.valid && cfg.ready)
				tag = cfg.data;
			if (cmd.valid && cmd.ready)
				step_poll_engine(cmd.kind, cmd.rx_byte);
			pending = awaited_results.size();
		end
	end

endmodule

[test/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Stimulus for the sound meter poll engine. A short directed run walks the
// init exchange and every packet outcome, then random request cycles follow
// under several tag settings, with random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
module tb import smpp_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0] KIND_UNUSED   = 2'd3;
	localparam int         ITEM_TARGET   = 460;
	localparam int         TAG_PHASES    = 6;
	localparam int         SETTLE_CYCLES = 6;
	localparam int         CYCLE_LIMIT   = 400000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	int          fail_count;
	int          pending;
	int unsigned cycle_count = 0;
	int          items_sent = 0;
	int          mix_items = 0;
	int          results_seen = 0;
	int          tag_settings = 0;
	logic [7:0]  tag_now = '0;
	bit          sender_quiet = 1'b0;
	bit          sink_quiet = 1'b0;

	smpp_cmd_if cmd ();
	smpp_cfg_if cfg ();
	smpp_res_if res ();

	sound_meter_poll_protocol dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.cfg    (cfg),
		.res    (res)
	);

	poll_protocol_checker checker_i (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.cfg        (cfg),
		.res        (res),
		.fail_count (fail_count),
		.pending    (pending)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Run stopped at the cycle limit with %0d results outstanding.", pending);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	task automatic send_item(input logic [1:0] kind, input logic [7:0] rx, input bit counted);
		int gap;
		gap = sender_quiet ? 0 : $urandom_range(0, 19);
		if (gap > 0) begin
			cmd.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd.valid <= 1'b1;
		cmd.kind <= kind;
		cmd.rx_byte <= rx;
		do @(posedge clk); while (!cmd.ready);
		items_sent++;
		if (counted)
			mix_items++;
	endtask

	// Waits at falling edges so that the checker's count is settled, then
	// gives an item with no result time to leave the pipeline.
	task automatic drain_results();
		cmd.valid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_tag(input logic [7:0] value);
		cfg.valid <= 1'b1;
		cfg.data <= value;
		do @(posedge clk); while (!cfg.ready);
		cfg.valid <= 1'b0;
		tag_now = value;
		tag_settings++;
	endtask

	task automatic send_packet(input logic [7:0] b0, input logic [7:0] b1,
		input logic [7:0] b2, input logic [7:0] b3, input bit counted);
		send_item(KIND_BYTE, b0, counted);
		send_item(KIND_BYTE, b1, counted);
		send_item(KIND_BYTE, b2, counted);
		send_item(KIND_BYTE, b3, counted);
	endtask

	// Items that the block drops while it is waiting for a reply.
	task automatic maybe_waiting_noise();
		if ($urandom_range(0, 11) == 0)
			send_item($urandom_range(0, 1) ? KIND_POLL : KIND_UNUSED, 8'($urandom), 1'b0);
	endtask

	task automatic run_request_cycle();
		int         cut;
		logic [7:0] b0, b1, b2, b3;
		sender_quiet = ($urandom_range(0, 3) == 0);
		// Bytes, timeouts and the unused kind are all dropped while sending.
		if ($urandom_range(0, 6) == 0) begin
			case ($urandom_range(0, 2))
				0: send_item(KIND_BYTE, 8'($urandom), 1'b0);
				1: send_item(KIND_TIMEOUT, 8'($urandom), 1'b0);
				default: send_item(KIND_UNUSED, 8'($urandom), 1'b0);
			endcase
		end
		send_item(KIND_POLL, 8'($urandom), 1'b1);
		maybe_waiting_noise();
		if ($urandom_range(0, 99) < 12) begin
			cut = $urandom_range(0, 3);
			for (int i = 0; i < cut; i++) begin
				send_item(KIND_BYTE, 8'($urandom), 1'b1);
				maybe_waiting_noise();
			end
			send_item(KIND_TIMEOUT, 8'($urandom), 1'b1);
		end else begin
			b0 = 8'($urandom);
			b1 = 8'($urandom);
			if ($urandom_range(0, 9) == 0) begin
				b0[2:0] = '0;
				b1 = '0;
			end
			b2 = tag_now + 8'd1;
			if ($urandom_range(0, 9) == 0)
				b2 = 8'($urandom);
			b3 = BYTE_CR;
			if ($urandom_range(0, 9) == 0)
				b3 = 8'($urandom);
			send_item(KIND_BYTE, b0, 1'b1);
			maybe_waiting_noise();
			send_item(KIND_BYTE, b1, 1'b1);
			maybe_waiting_noise();
			send_item(KIND_BYTE, b2, 1'b1);
			send_item(KIND_BYTE, b3, 1'b1);
		end
	endtask

	// Result side: a random stall before each transaction, quiet stretches
	// with none, and two long hold-offs that back the engine up.
	initial begin
		int stall;
		res.ready <= 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (results_seen % 40 == 0)
				sink_quiet = ($urandom_range(0, 2) == 0);
			if (results_seen == 120 || results_seen == 360)
				stall = $urandom_range(60, 90);
			else if (sink_quiet)
				stall = 0;
			else
				stall = $urandom_range(0, 19);
			if (stall > 0) begin
				res.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			res.ready <= 1'b1;
			do @(posedge clk); while (!res.valid);
			results_seen++;
		end
	end

	initial begin
		logic [7:0] phase_tag;
		cmd.valid <= 1'b0;
		cmd.kind <= KIND_POLL;
		cmd.rx_byte <= '0;
		cfg.valid <= 1'b0;
		cfg.data <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_tag(8'h00);
		// Dropped items in the init sending phase, then the init command.
		send_item(KIND_BYTE, 8'hff, 1'b0);
		send_item(KIND_TIMEOUT, 8'h00, 1'b0);
		send_item(KIND_UNUSED, 8'h5a, 1'b0);
		send_item(KIND_POLL, 8'h00, 1'b0);
		send_item(KIND_POLL, 8'hff, 1'b0);
		send_item(KIND_BYTE, INIT_ACK, 1'b0);
		send_item(KIND_BYTE, 8'h0c, 1'b0);
		// The init phase is left for good once, so each run takes one exit.
		send_item(KIND_POLL, 8'h00, 1'b0);
		if ($urandom_range(0, 1)) begin
			send_item(KIND_BYTE, INIT_ACK, 1'b0);
			send_item(KIND_BYTE, BYTE_CR, 1'b0);
		end else begin
			send_item(KIND_TIMEOUT, 8'h00, 1'b0);
		end
		send_item(KIND_POLL, 8'h00, 1'b0);
		send_packet(8'hff, 8'hff, 8'h01, BYTE_CR, 1'b0);
		send_item(KIND_POLL, 8'h00, 1'b0);
		send_packet(8'h00, 8'h00, 8'h01, BYTE_CR, 1'b0);
		send_item(KIND_POLL, 8'h00, 1'b0);
		send_packet(8'h88, 8'h10, 8'h02, BYTE_CR, 1'b0);
		send_item(KIND_POLL, 8'h00, 1'b0);
		send_item(KIND_TIMEOUT, 8'h00, 1'b0);

		// The largest tag wraps the expected third byte round to zero.
		drain_results();
		write_tag(8'hff);
		send_item(KIND_POLL, 8'h00, 1'b0);
		send_packet(8'h37, 8'h4a, 8'h00, BYTE_CR, 1'b0);

		for (int p = 0; p < TAG_PHASES; p++) begin
			case (p)
				0: phase_tag = 8'hfe;
				2: phase_tag = 8'h00;
				default: phase_tag = 8'($urandom_range(0, 254));
			endcase
			drain_results();
			write_tag(phase_tag);
			while (mix_items < ITEM_TARGET * (p + 1) / TAG_PHASES) begin
				run_request_cycle();
				// Now and then the sender waits for every result to arrive.
				if ($urandom_range(0, 19) == 0)
					drain_results();
			end
		end

		drain_results();
		repeat (10) @(posedge clk);
		$display("Covered %0d input items (%0d in the random request mix) over %0d tag settings.",
			items_sent, mix_items, tag_settings);
		$display("Checked %0d result transactions under random stalls and long hold-offs.",
			results_seen);
		if (fail_count == 0 && pending == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

[sound_meter_poll_protocol.f]
+incdir+rtl
rtl/smpp_pkg.sv
rtl/smpp_if.sv
rtl/smpp_step.sv
rtl/sound_meter_poll_protocol.sv
rtl/smpp_checker.sv
test/poll_protocol_checker.sv
test/tb.sv
